@@ hdl/scoped_delimiter_tokenizer_macros.svh @@
// Assertion macros shared by the tokenizer RTL files.
`ifndef SCOPED_DELIMITER_TOKENIZER_MACROS_SVH
`define SCOPED_DELIMITER_TOKENIZER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define SDT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define SDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SDT_ASSERT_IMPL(lbl, ante, cons, msg)
`define SDT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hdl/sdt_pkg.sv @@
// Shared constants, types and set-match function for the scoped delimiter tokenizer.
package sdt_pkg;

    localparam int DEPTH_BITS = 8;
    localparam int SET_SLOTS  = 8;
    localparam int SLOT_BITS  = 8;
    localparam int SET_BITS   = 64;
    localparam int CHAR_BITS  = 8;
    localparam int DOUT_BITS  = 8;
    localparam int STAT_BITS  = 2;
    localparam int CFG_IDX_BITS = 2;

    // Result status codes.
    localparam logic [STAT_BITS-1:0] ST_RUN       = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_DONE      = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_UNMATCHED = 2'd2;
    localparam logic [STAT_BITS-1:0] ST_OVERFLOW  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_DELIM_SET = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OPEN_SET  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLOSE_SET = 2'd2;

    // Reset values of the byte sets: a single space delimiter, no brackets.
    localparam logic [SET_BITS-1:0] DELIM_SET_RESET = 64'd32;
    localparam logic [SET_BITS-1:0] OPEN_SET_RESET  = 64'd0;
    localparam logic [SET_BITS-1:0] CLOSE_SET_RESET = 64'd0;

    typedef struct packed {
        logic [CHAR_BITS-1:0] char_out;
        logic                 in_token;
        logic                 token_start;
        logic                 token_end;
        logic [STAT_BITS-1:0] status;
        logic [DOUT_BITS-1:0] depth_out;
    } result_t;

    typedef struct packed {
        logic [SET_BITS-1:0] delim_set;
        logic [SET_BITS-1:0] open_set;
        logic [SET_BITS-1:0] close_set;
    } sets_t;

    // True when the byte equals a nonempty slot of the set.
    function automatic logic in_set(input logic [SET_BITS-1:0] set,
                                    input logic [CHAR_BITS-1:0] c);
        logic hit;
        logic [SLOT_BITS-1:0] slot;
        hit = 1'b0;
        for (int i = 0; i < SET_SLOTS; i++) begin
            slot = set[i*SLOT_BITS +: SLOT_BITS];
            if (slot != '0 && slot == c) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

@@ hdl/sdt_core.sv @@
// Tokenizer phase and nesting-depth state with the per-byte decision logic.
`include "scoped_delimiter_tokenizer_macros.svh"

module sdt_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               step_i,
    input  logic [sdt_pkg::CHAR_BITS-1:0]      char_i,
    input  logic                               last_i,
    input  sdt_pkg::sets_t                     sets_i,
    output sdt_pkg::result_t                   res_o
);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_TOKEN,
        PH_HALT
    } phase_t;

    localparam logic [sdt_pkg::DEPTH_BITS-1:0] DEPTH_MAX = '1;
    localparam int CMP_W = (sdt_pkg::DEPTH_BITS > sdt_pkg::DOUT_BITS) ?
                           sdt_pkg::DEPTH_BITS : sdt_pkg::DOUT_BITS;
    localparam logic [sdt_pkg::DOUT_BITS-1:0] DOUT_MAX = '1;

    phase_t                          phase_reg, phase_next;
    logic [sdt_pkg::DEPTH_BITS-1:0]  depth_reg, depth_next;

    logic                            is_delim, is_open, is_close;
    logic [sdt_pkg::STAT_BITS-1:0]   scope_st;
    logic [sdt_pkg::DEPTH_BITS-1:0]  scope_depth;
    logic                            tok, start, tend;
    logic [sdt_pkg::STAT_BITS-1:0]   st;
    logic [CMP_W-1:0]                depth_ext;

    assign is_delim = sdt_pkg::in_set(sets_i.delim_set, char_i);
    assign is_open  = sdt_pkg::in_set(sets_i.open_set,  char_i);
    assign is_close = sdt_pkg::in_set(sets_i.close_set, char_i);

    // Open wins over close when a byte is in both sets.
    always_comb begin
        scope_st    = sdt_pkg::ST_RUN;
        scope_depth = depth_reg;
        priority if (is_open) begin
            if (depth_reg == DEPTH_MAX) begin
                scope_st = sdt_pkg::ST_OVERFLOW;
            end else begin
                scope_depth = depth_reg + 1'b1;
            end
        end else if (is_close) begin
            if (depth_reg == '0) begin
                scope_st = sdt_pkg::ST_UNMATCHED;
            end else begin
                scope_depth = depth_reg - 1'b1;
            end
        end else begin
            scope_depth = depth_reg;
        end
    end

    always_comb begin
        tok        = 1'b0;
        start      = 1'b0;
        tend       = 1'b0;
        st         = sdt_pkg::ST_RUN;
        phase_next = phase_reg;
        depth_next = depth_reg;

        unique case (phase_reg)
            PH_TOKEN: begin
                if (is_delim && depth_reg == '0) begin
                    tend       = 1'b1;
                    phase_next = PH_SKIP;
                end else begin
                    tok        = 1'b1;
                    st         = scope_st;
                    depth_next = scope_depth;
                end
            end
            PH_SKIP: begin
                if (!is_delim && depth_reg == '0) begin
                    phase_next = PH_TOKEN;
                    tok        = 1'b1;
                    start      = 1'b1;
                end
                st         = scope_st;
                depth_next = scope_depth;
            end
            default: begin
                st = sdt_pkg::ST_UNMATCHED;
            end
        endcase

        // A stray close voids the current token and halts the string.
        if (st == sdt_pkg::ST_UNMATCHED) begin
            phase_next = PH_HALT;
            depth_next = '0;
            tok        = 1'b0;
            start      = 1'b0;
            tend       = 1'b0;
        end

        if (last_i) begin
            if (phase_next == PH_TOKEN) begin
                tend = 1'b1;
                if (st == sdt_pkg::ST_RUN) begin
                    st = sdt_pkg::ST_DONE;
                end
            end else if (phase_next == PH_SKIP) begin
                if (depth_next != '0) begin
                    st = sdt_pkg::ST_UNMATCHED;
                end else if (st == sdt_pkg::ST_RUN) begin
                    st = sdt_pkg::ST_DONE;
                end
            end
        end
    end

    assign depth_ext = CMP_W'(depth_next);

    always_comb begin
        res_o.char_out    = char_i;
        res_o.in_token    = tok;
        res_o.token_start = start;
        res_o.token_end   = tend;
        res_o.status      = st;
        res_o.depth_out   = (depth_ext > CMP_W'(DOUT_MAX)) ? DOUT_MAX :
                            depth_ext[sdt_pkg::DOUT_BITS-1:0];
    end

    // The last byte of a string returns the state to its reset value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SKIP;
            depth_reg <= '0;
        end else if (step_i) begin
            if (last_i) begin
                phase_reg <= PH_SKIP;
                depth_reg <= '0;
            end else begin
                phase_reg <= phase_next;
                depth_reg <= depth_next;
            end
        end
    end

    `SDT_ASSERT_IMPL(a_halt_depth_zero, phase_reg == PH_HALT, depth_reg == '0,
        "halted with nonzero depth")
    `SDT_ASSERT_NEXT(a_last_resets, step_i && last_i,
        phase_reg == PH_SKIP && depth_reg == '0, "state not cleared after last byte")
    `SDT_ASSERT_IMPL(a_start_from_skip, step_i && res_o.token_start,
        phase_reg == PH_SKIP && res_o.in_token, "token start outside skip phase")

endmodule

@@ hdl/scoped_delimiter_tokenizer.sv @@
// Top level of the scoped delimiter tokenizer: stream ports, set registers, beat pipeline.
// An accepted input beat passes the input register, then the result register, before its result
// beat is offered on m_tvalid; throughput is one beat per cycle while m_tready does not stall the output.
// The byte decision is one pass of parallel set compares and a depth step.
// Reset (aresetn low at a rising edge) empties both registers, restores the
// default sets (space delimiter, no brackets) and returns to skipping at depth zero.
`include "scoped_delimiter_tokenizer_macros.svh"

module scoped_delimiter_tokenizer (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [sdt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [sdt_pkg::SET_BITS-1:0]        cfg_data,
    // Input byte stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // [7:0] char_code
    input  logic                                s_tlast,  // is_last
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,  // [7:0] char_out, [8] in_token,
                                                          // [9] token_start,
                                                          // [17:10] depth_out, [23:18] zero
    output logic                                m_tlast,  // token_end
    output logic [1:0]                          m_tuser   // [1:0] status
);

    sdt_pkg::sets_t                     sets_reg;

    logic                               in_valid_reg;
    logic [sdt_pkg::CHAR_BITS-1:0]      in_char_reg;
    logic                               in_last_reg;

    logic                               out_valid_reg;
    sdt_pkg::result_t                   out_res_reg;

    sdt_pkg::result_t                   res;
    logic                               advance;
    logic                               s_accept;

    // The input beat moves on whenever the result register is free or being
    // drained. A new byte enters while the input register is empty or moving on,
    // so only a stalled result with a full input register holds the input off.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sets_reg.delim_set <= sdt_pkg::DELIM_SET_RESET;
            sets_reg.open_set  <= sdt_pkg::OPEN_SET_RESET;
            sets_reg.close_set <= sdt_pkg::CLOSE_SET_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sdt_pkg::CFG_DELIM_SET: sets_reg.delim_set <= cfg_data;
                sdt_pkg::CFG_OPEN_SET:  sets_reg.open_set  <= cfg_data;
                sdt_pkg::CFG_CLOSE_SET: sets_reg.close_set <= cfg_data;
                default: begin
                    // Writes beyond the register list are dropped.
                    sets_reg <= sets_reg;
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_accept) begin
            in_char_reg <= s_tdata[sdt_pkg::CHAR_BITS-1:0];
            in_last_reg <= s_tlast;
        end
    end

    sdt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_i  (advance),
        .char_i  (in_char_reg),
        .last_i  (in_last_reg),
        .sets_i  (sets_reg),
        .res_o   (res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_res_reg.depth_out, out_res_reg.token_start,
                       out_res_reg.in_token, out_res_reg.char_out};
    assign m_tlast  = out_res_reg.token_end;
    assign m_tuser  = out_res_reg.status;

    `SDT_ASSERT_NEXT(a_in_holds, in_valid_reg && !advance, in_valid_reg,
        "input beat lost while stalled")
    `SDT_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg,
        "advanced beat missing from result register")
    `SDT_ASSERT_IMPL(a_start_in_token, m_tvalid && m_tdata[9], m_tdata[8],
        "token start on a byte outside a token")

endmodule

@@ tb/scoped_delimiter_tokenizer_test.sv @@
// Self-checking testbench for the scoped delimiter tokenizer: directed table, then random strings.
module scoped_delimiter_tokenizer_test;

    // A run of this many cycles with no beat and no register write means the block is stuck.
    localparam int QUIET_LIMIT = 1000;
    // Number of cycles the receiver holds m_tready low during the deep nesting string.
    localparam int HOLD_CYCLES = 64;
    // Byte budget of every random phase; eight phases plus the deep string give about 950.
    localparam int PHASE_BYTES = 80;

    // The predictor tracks the same three phases as the block.
    typedef enum logic [1:0] {SCAN_SKIP, SCAN_TOKEN, SCAN_HALT} scan_phase_t;
    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

    // One line of the directed table: either a register write or a byte, and for the
    // rows whose outcome is obvious, the result beat typed in by hand.
    typedef struct {
        row_kind_t                         kind;
        logic [sdt_pkg::CFG_IDX_BITS-1:0]  idx;
        logic [sdt_pkg::SET_BITS-1:0]      data;
        logic [sdt_pkg::CHAR_BITS-1:0]     c;
        logic                              last;
        bit                                typed_in;
        sdt_pkg::result_t                  want;
    } stim_row_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [sdt_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [sdt_pkg::SET_BITS-1:0]     cfg_data = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [7:0]                       s_tdata = 8'h00;
    logic                             s_tlast = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [23:0]                      m_tdata;
    logic                             m_tlast;
    logic [1:0]                       m_tuser;

    // Predictor state: the three byte sets and the scan position within the current string.
    logic [sdt_pkg::SET_BITS-1:0]     delim_bytes;
    logic [sdt_pkg::SET_BITS-1:0]     open_bytes;
    logic [sdt_pkg::SET_BITS-1:0]     close_bytes;
    scan_phase_t                      scan;
    logic [sdt_pkg::DEPTH_BITS-1:0]   nest;

    // Result beats predicted for accepted bytes, oldest first.
    sdt_pkg::result_t        pending_marks[$];
    stim_row_t               rows[$];

    int unsigned fail_count = 0;
    int unsigned results_seen = 0;
    int unsigned n_bytes = 0;
    int unsigned n_strings = 0;
    int unsigned n_tokens = 0;
    int unsigned n_overflow = 0;
    int unsigned n_unmatched = 0;
    int unsigned n_configs = 0;
    int unsigned quiet = 0;
    bit          steady = 1'b0;
    bit          hold_req = 1'b0;
    bit          held_off = 1'b0;

    scoped_delimiter_tokenizer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A byte matches a set when it equals one of the nonempty slots.
    function automatic logic is_member(logic [sdt_pkg::SET_BITS-1:0] set,
                                       logic [sdt_pkg::CHAR_BITS-1:0] c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < sdt_pkg::SET_SLOTS; i++) begin
            hit |= (set[i*sdt_pkg::SLOT_BITS +: sdt_pkg::SLOT_BITS] == c) &&
                   (set[i*sdt_pkg::SLOT_BITS +: sdt_pkg::SLOT_BITS] != '0);
        end
        return hit;
    endfunction

    // Opening bytes take precedence over closing ones. The depth saturates at its top
    // value, and closing at depth zero is reported to the caller as an unmatched scope.
    function automatic logic [sdt_pkg::STAT_BITS-1:0] nest_step(
            logic [sdt_pkg::CHAR_BITS-1:0] c);
        if (is_member(open_bytes, c)) begin
            if (nest == '1) begin
                return sdt_pkg::ST_OVERFLOW;
            end
            nest = nest + 1'b1;
        end else if (is_member(close_bytes, c)) begin
            if (nest == '0) begin
                return sdt_pkg::ST_UNMATCHED;
            end
            nest = nest - 1'b1;
        end
        return sdt_pkg::ST_RUN;
    endfunction

    // Works out the result beat for one accepted byte and advances the scan state.
    function automatic sdt_pkg::result_t tokenize_byte(logic [sdt_pkg::CHAR_BITS-1:0] c,
                                                       logic last);
        sdt_pkg::result_t              mark;
        logic [sdt_pkg::STAT_BITS-1:0] status;
        logic                          is_delim;
        int unsigned                   depth_now;
        mark = '0;
        mark.char_out = c;
        status = sdt_pkg::ST_RUN;
        is_delim = is_member(delim_bytes, c);
        case (scan)
            SCAN_HALT: begin
                status = sdt_pkg::ST_UNMATCHED;
            end
            SCAN_TOKEN: begin
                // A delimiter closes the token only outside every bracket.
                if (is_delim && nest == '0) begin
                    mark.token_end = 1'b1;
                    scan = SCAN_SKIP;
                end else begin
                    mark.in_token = 1'b1;
                    status = nest_step(c);
                end
            end
            default: begin
                if (!is_delim && nest == '0) begin
                    scan = SCAN_TOKEN;
                    mark.in_token = 1'b1;
                    mark.token_start = 1'b1;
                end
                status = nest_step(c);
            end
        endcase
        // An unmatched close voids the token and halts the scan until the string ends.
        if (status == sdt_pkg::ST_UNMATCHED) begin
            scan = SCAN_HALT;
            nest = '0;
            mark.in_token = 1'b0;
            mark.token_start = 1'b0;
            mark.token_end = 1'b0;
        end
        if (last) begin
            if (scan == SCAN_TOKEN) begin
                mark.token_end = 1'b1;
                if (status == sdt_pkg::ST_RUN) begin
                    status = sdt_pkg::ST_DONE;
                end
            end else if (scan == SCAN_SKIP) begin
                if (nest != '0) begin
                    status = sdt_pkg::ST_UNMATCHED;
                end else if (status == sdt_pkg::ST_RUN) begin
                    status = sdt_pkg::ST_DONE;
                end
            end
        end
        depth_now = nest;
        mark.depth_out = (depth_now > 255) ? 8'hFF : 8'(depth_now);
        mark.status = status;
        if (last) begin
            scan = SCAN_SKIP;
            nest = '0;
        end
        return mark;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one byte, idling at random first, and records its prediction on acceptance.
    // Inputs are sampled right after the edge, so every read sees the pre-edge values.
    task automatic push_byte(logic [sdt_pkg::CHAR_BITS-1:0] c, logic last, bit typed_in,
                             sdt_pkg::result_t want);
        sdt_pkg::result_t mark;
        while (!steady && $urandom_range(99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        mark = tokenize_byte(c, last);
        pending_marks.push_back(typed_in ? want : mark);
        n_bytes++;
        if (mark.token_start) begin
            n_tokens++;
        end
        if (mark.status == sdt_pkg::ST_OVERFLOW) begin
            n_overflow++;
        end
        if (mark.status == sdt_pkg::ST_UNMATCHED) begin
            n_unmatched++;
        end
    endtask

    // Set registers change only once the block has delivered every pending beat.
    task automatic write_reg(logic [sdt_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [sdt_pkg::SET_BITS-1:0] data);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_marks.size() != 0) begin
            @(posedge aclk);
        end
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            sdt_pkg::CFG_DELIM_SET: delim_bytes = data;
            sdt_pkg::CFG_OPEN_SET:  open_bytes = data;
            sdt_pkg::CFG_CLOSE_SET: close_bytes = data;
            default: ;
        endcase
    endtask

    task automatic write_sets(logic [sdt_pkg::SET_BITS-1:0] d, logic [sdt_pkg::SET_BITS-1:0] o,
                              logic [sdt_pkg::SET_BITS-1:0] cl);
        write_reg(sdt_pkg::CFG_DELIM_SET, d);
        write_reg(sdt_pkg::CFG_OPEN_SET, o);
        write_reg(sdt_pkg::CFG_CLOSE_SET, cl);
        n_configs++;
    endtask

    // Random set: each slot is empty one time in four, otherwise any nonzero byte.
    function automatic logic [sdt_pkg::SET_BITS-1:0] rand_set();
        logic [sdt_pkg::SET_BITS-1:0] set;
        for (int i = 0; i < sdt_pkg::SET_SLOTS; i++) begin
            set[i*sdt_pkg::SLOT_BITS +: sdt_pkg::SLOT_BITS] =
                ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        end
        return set;
    endfunction

    // Draws one member of a set, or any nonzero byte when the set is empty.
    function automatic logic [sdt_pkg::CHAR_BITS-1:0] pick_member(
            logic [sdt_pkg::SET_BITS-1:0] set);
        logic [sdt_pkg::CHAR_BITS-1:0] slots[$];
        for (int i = 0; i < sdt_pkg::SET_SLOTS; i++) begin
            if (set[i*sdt_pkg::SLOT_BITS +: sdt_pkg::SLOT_BITS] != '0) begin
                slots.push_back(set[i*sdt_pkg::SLOT_BITS +: sdt_pkg::SLOT_BITS]);
            end
        end
        if (slots.size() == 0) begin
            return 8'($urandom_range(1, 255));
        end
        return slots[$urandom_range(slots.size() - 1)];
    endfunction

    // One string of random content. A tidy string keeps its brackets balanced so that
    // it walks through tokens, nesting and clean ends; an untidy one is plain noise
    // that tends to provoke unmatched closes and strings ending inside a scope.
    task automatic send_string(bit tidy);
        int                            len;
        int                            depth_gen;
        int                            roll;
        logic [sdt_pkg::CHAR_BITS-1:0] c;
        len = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        depth_gen = 0;
        for (int i = 0; i < len; i++) begin
            roll = $urandom_range(99);
            if (!tidy) begin
                if (roll < 50) begin
                    c = 8'($urandom_range(1, 255));
                end else if (roll < 67) begin
                    c = pick_member(delim_bytes);
                end else if (roll < 84) begin
                    c = pick_member(open_bytes);
                end else begin
                    c = pick_member(close_bytes);
                end
            end else if (depth_gen > 0 && len - i <= depth_gen) begin
                // Close what is still open before the string runs out.
                c = pick_member(close_bytes);
                depth_gen--;
            end else if (roll < 25) begin
                c = pick_member(delim_bytes);
            end else if (roll < 40) begin
                c = pick_member(open_bytes);
                depth_gen++;
            end else if (roll < 55 && depth_gen > 0) begin
                c = pick_member(close_bytes);
                depth_gen--;
            end else begin
                c = 8'($urandom_range(1, 255));
            end
            push_byte(c, i == len - 1, 1'b0, '0);
        end
        n_strings++;
    endtask

    task automatic add_cfg(logic [sdt_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [sdt_pkg::SET_BITS-1:0] data);
        stim_row_t row;
        row = '{kind: ROW_CFG, default: '0};
        row.idx = idx;
        row.data = data;
        rows.push_back(row);
    endtask

    task automatic add_byte(logic [sdt_pkg::CHAR_BITS-1:0] c, logic last);
        stim_row_t row;
        row = '{kind: ROW_BYTE, default: '0};
        row.c = c;
        row.last = last;
        rows.push_back(row);
    endtask

    task automatic add_fixed(logic [sdt_pkg::CHAR_BITS-1:0] c, logic last, logic tok, logic st,
                             logic en, logic [sdt_pkg::STAT_BITS-1:0] status,
                             logic [7:0] depth);
        stim_row_t row;
        row = '{kind: ROW_BYTE, default: '0};
        row.c = c;
        row.last = last;
        row.typed_in = 1'b1;
        row.want.char_out = c;
        row.want.in_token = tok;
        row.want.token_start = st;
        row.want.token_end = en;
        row.want.status = status;
        row.want.depth_out = depth;
        rows.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure, one long hold-off, and the checker
    // ------------------------------------------------------------------

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req && !held_off) begin
                // Hold off long enough that the pipeline fills and s_tready drops.
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                held_off = 1'b1;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 21);
            end
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        sdt_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_marks.size() == 0) begin
                $error("result beat with nothing expected: tdata %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_marks.pop_front();
                check_field("char_out", 32'(want.char_out), 32'(m_tdata[7:0]));
                check_field("in_token", 32'(want.in_token), 32'(m_tdata[8]));
                check_field("token_start", 32'(want.token_start), 32'(m_tdata[9]));
                check_field("depth_out", 32'(want.depth_out), 32'(m_tdata[17:10]));
                check_field("tdata padding", 32'd0, 32'(m_tdata[23:18]));
                check_field("token_end", 32'(want.token_end), 32'(m_tlast));
                check_field("status", 32'(want.status), 32'(m_tuser));
            end
        end
    end

    // Watchdog: ends the run if neither side moves a beat for too long.
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet == QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        int unsigned                   phase_start;
        logic [sdt_pkg::SET_BITS-1:0]  d;
        logic [sdt_pkg::SET_BITS-1:0]  o;
        logic [sdt_pkg::SET_BITS-1:0]  cl;

        delim_bytes = sdt_pkg::DELIM_SET_RESET;
        open_bytes = sdt_pkg::OPEN_SET_RESET;
        close_bytes = sdt_pkg::CLOSE_SET_RESET;
        scan = SCAN_SKIP;
        nest = '0;

        // Default sets after reset: space is the only delimiter and there are no brackets.
        add_fixed("a", 1'b0, 1'b1, 1'b1, 1'b0, sdt_pkg::ST_RUN, 8'd0);
        add_fixed(" ", 1'b0, 1'b0, 1'b0, 1'b1, sdt_pkg::ST_RUN, 8'd0);
        add_fixed(" ", 1'b0, 1'b0, 1'b0, 1'b0, sdt_pkg::ST_RUN, 8'd0);
        add_fixed(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, sdt_pkg::ST_DONE, 8'd0);
        add_fixed(8'h01, 1'b1, 1'b1, 1'b1, 1'b1, sdt_pkg::ST_DONE, 8'd0);
        add_fixed(" ", 1'b1, 1'b0, 1'b0, 1'b0, sdt_pkg::ST_DONE, 8'd0);

        // Delimiters space, comma, semicolon and 0xFF in the top slot. The semicolon is
        // also an opening byte, and square brackets sit in the top slot of their sets.
        add_cfg(sdt_pkg::CFG_DELIM_SET, 64'hFF00_0000_003B_2C20);
        add_cfg(sdt_pkg::CFG_OPEN_SET, 64'h5B00_0000_0000_3B28);
        add_cfg(sdt_pkg::CFG_CLOSE_SET, 64'h5D00_0000_0000_0029);

        // A token opened by a bracket keeps a comma inside its scope.
        add_byte("(", 1'b0);
        add_byte(",", 1'b0);
        add_byte("]", 1'b0);
        add_byte(",", 1'b0);
        // Delimiter that also opens: no token starts but the depth rises, and the
        // string then ends while still skipping inside a scope.
        add_byte(";", 1'b0);
        add_byte("x", 1'b0);
        add_byte(8'hFF, 1'b1);
        // Close at depth zero while skipping halts the scan until the last byte.
        add_fixed(")", 1'b0, 1'b0, 1'b0, 1'b0, sdt_pkg::ST_UNMATCHED, 8'd0);
        add_fixed("a", 1'b0, 1'b0, 1'b0, 1'b0, sdt_pkg::ST_UNMATCHED, 8'd0);
        add_fixed("b", 1'b1, 1'b0, 1'b0, 1'b0, sdt_pkg::ST_UNMATCHED, 8'd0);
        // Close at depth zero inside a token voids that token.
        add_byte("k", 1'b0);
        add_fixed(")", 1'b0, 1'b0, 1'b0, 1'b0, sdt_pkg::ST_UNMATCHED, 8'd0);
        add_byte("z", 1'b1);
        // Last byte inside a token that is still nested closes it cleanly.
        add_byte("[", 1'b0);
        add_byte("m", 1'b1);
        add_byte(8'h80, 1'b0);
        add_byte(8'h7F, 1'b1);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                write_reg(rows[i].idx, rows[i].data);
            end else begin
                push_byte(rows[i].c, rows[i].last, rows[i].typed_in, rows[i].want);
            end
        end
        n_configs += 2;
        n_strings += 8;

        // Random part: eight set configurations, the first two at the extremes (all slots
        // empty, all slots 0xFF), then a bracket-heavy printable set, then random sets.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    d = '0;
                    o = '0;
                    cl = '0;
                end
                1: begin
                    d = '1;
                    o = '1;
                    cl = '1;
                end
                2: begin
                    d = 64'h0000_0000_3B2C_0920;
                    o = 64'h0000_0000_7B5B_3C28;
                    cl = 64'h0000_0000_7D5D_3E29;
                end
                default: begin
                    d = rand_set();
                    o = rand_set();
                    cl = rand_set();
                end
            endcase
            write_sets(d, o, cl);
            // One phase runs with both sides fully busy.
            steady = (ph == 4);

            if (ph == 2) begin
                // Deep nesting inside one token: the depth saturates, a close and an open
                // bring it back to the top without overflow, and the string ends on a
                // further overflow, which outranks the clean finish. The receiver stalls
                // meanwhile so the block backs up onto its input.
                hold_req = 1'b1;
                push_byte("a", 1'b0, 1'b0, '0);
                for (int k = 0; k < 256; k++) begin
                    push_byte("(", 1'b0, 1'b0, '0);
                end
                push_byte(")", 1'b0, 1'b0, '0);
                push_byte("(", 1'b0, 1'b0, '0);
                push_byte("(", 1'b1, 1'b0, '0);
                n_strings++;
            end

            phase_start = n_bytes;
            while (n_bytes - phase_start < PHASE_BYTES) begin
                send_string($urandom_range(99) < 75);
            end
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        while (pending_marks.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        $display("Sent %0d bytes in %0d strings over %0d set configurations.",
                 n_bytes, n_strings, n_configs);
        $display("Saw %0d tokens, %0d depth overflow beats and %0d unmatched scope beats.",
                 n_tokens, n_overflow, n_unmatched);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
